@@ rtl/assert_macros.svh @@
// Assertion macros shared by the ring queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clk, masked while arst_n is low
`define RCRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge
`define RCRQ_NEVER(lbl, expr, msg) \
	`RCRQ_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/rcrq_pkg.sv @@
// Types, constants and helpers for the reserve/commit ring queue
`default_nettype none

package rcrq_pkg;

	localparam int NUM_ENTRIES  = 64;
	localparam int HEADER_BYTES = 4;
	localparam int MAX_PAYLOAD  = 248;

	localparam int IDX_W   = $clog2(NUM_ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int LEN_W   = 8;
	localparam int SLOT_W  = 6;
	localparam int LOST_W  = 32;
	localparam int LEVEL_W = 7;

	typedef enum logic [2:0] {
		OP_ACQUIRE = 3'd0,
		OP_COMMIT  = 3'd1,
		OP_PEEK    = 3'd2,
		OP_RELEASE = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_PENDING = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [LEN_W-1:0]  request_len;
		logic [LEN_W-1:0]  commit_len;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] peek_offset;
		logic              flush_req;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  out_slot;
		logic [LEN_W-1:0]   out_len;
		logic [LOST_W-1:0]  lost_count;
		logic [LEVEL_W-1:0] fill_level;
		logic               flush_pending;
	} rsp_beat_t;

	// one slot record: committed bit and stored length including header
	typedef struct packed {
		logic             committed;
		logic [LEN_W-1:0] len;
	} slot_info_t;

	localparam int SLOT_INFO_W = $bits(slot_info_t);

	// result under way to the output stage, finished once the slot read returns
	typedef struct packed {
		rsp_beat_t res;
		logic      peek_hit;
		logic      entry_vld;
	} s1_t;

	function automatic logic [LEN_W-1:0] sat_payload(input logic [LEN_W:0] v);
		logic [LEN_W-1:0] r;
		if (v > (LEN_W+1)'(MAX_PAYLOAD))
			r = LEN_W'(MAX_PAYLOAD);
		else
			r = v[LEN_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rcrq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module rcrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/rcrq_core.sv @@
// Pointer, loss counter and flag bookkeeping; issues slot writes and peek reads
`default_nettype none
`include "assert_macros.svh"

module rcrq_core import rcrq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  req_beat_t        req,
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_waddr,
	output slot_info_t       ram_wdata,
	output logic             ram_re,
	output logic [IDX_W-1:0] ram_raddr,
	output s1_t              s1_d
);

	logic [CNT_W-1:0]       head_q, tail_q, head_d, tail_d;
	logic [LOST_W-1:0]      lost_q, lost_d;
	logic                   flush_q, flush_d;
	logic [NUM_ENTRIES-1:0] vld_q;
	logic [CNT_W-1:0]       level;
	logic                   full;
	logic [LEN_W-1:0]       aligned;
	logic                   we_c, re_c, clr_c;
	logic [IDX_W-1:0]       peek_addr;

	assign level     = head_q - tail_q;
	assign full      = (level == CNT_W'(NUM_ENTRIES));
	assign aligned   = sat_payload(({1'b0, req.request_len} + (LEN_W+1)'(3)) &
		~(LEN_W+1)'(3));
	assign peek_addr = tail_q[IDX_W-1:0] + IDX_W'(req.peek_offset);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		lost_d    = lost_q;
		flush_d   = flush_q;
		we_c      = 1'b0;
		re_c      = 1'b0;
		clr_c     = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = peek_addr;
		s1_d      = '0;
		s1_d.res.status = ST_OK;
		case (req.op)
			OP_ACQUIRE: begin
				if (full) begin
					s1_d.res.status = ST_FULL;
					if (lost_q != '1)
						lost_d = lost_q + LOST_W'(1);
				end else begin
					we_c                = 1'b1;
					ram_waddr           = head_q[IDX_W-1:0];
					ram_wdata.committed = 1'b0;
					ram_wdata.len       = aligned + LEN_W'(HEADER_BYTES);
					head_d              = head_q + CNT_W'(1);
					s1_d.res.out_slot   = SLOT_W'(head_q[IDX_W-1:0]);
					s1_d.res.out_len    = aligned;
				end
			end
			OP_COMMIT: begin
				flush_d             = flush_q | req.flush_req;
				we_c                = 1'b1;
				ram_waddr           = IDX_W'(req.slot);
				ram_wdata.committed = 1'b1;
				ram_wdata.len       = sat_payload({1'b0, req.commit_len}) +
					LEN_W'(HEADER_BYTES);
			end
			OP_PEEK: begin
				s1_d.res.lost_count = lost_q;
				lost_d              = '0;
				if (CNT_W'(req.peek_offset) >= level) begin
					s1_d.res.status = ST_EMPTY;
				end else begin
					re_c              = 1'b1;
					s1_d.res.out_slot = SLOT_W'(peek_addr);
					s1_d.peek_hit     = 1'b1;
					s1_d.entry_vld    = vld_q[peek_addr];
				end
			end
			OP_RELEASE: begin
				if (level == '0) begin
					s1_d.res.status = ST_EMPTY;
				end else begin
					we_c      = 1'b1;
					ram_waddr = IDX_W'(req.slot);
					tail_d    = tail_q + CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				clr_c   = 1'b1;
				head_d  = '0;
				tail_d  = '0;
				lost_d  = '0;
				flush_d = 1'b0;
			end
			default: begin
			end
		endcase
		s1_d.res.fill_level    = LEVEL_W'(head_d - tail_d);
		s1_d.res.flush_pending = flush_d;
	end

	assign ram_we = acc & we_c;
	assign ram_re = acc & re_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			lost_q  <= '0;
			flush_q <= 1'b0;
			vld_q   <= '0;
		end else if (acc) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			lost_q  <= lost_d;
			flush_q <= flush_d;
			// entries never written since clear read as uncommitted
			if (clr_c)
				vld_q <= '0;
			else if (we_c)
				vld_q[ram_waddr] <= 1'b1;
		end
	end

	`RCRQ_NEVER(a_level_range, level > CNT_W'(NUM_ENTRIES), "fill level above ring size")
	`RCRQ_ASSERT(a_full_no_adv, (acc && req.op == OP_ACQUIRE && full) |=> $stable(head_q), "head moved on overrun")
	`RCRQ_ASSERT(a_empty_no_rel, (acc && req.op == OP_RELEASE && level == '0) |=> $stable(tail_q), "tail moved on empty release")
	`RCRQ_ASSERT(a_clear_empty, (acc && req.op == OP_CLEAR) |=> (level == '0 && vld_q == '0), "clear left entries")

endmodule

`default_nettype wire

@@ rtl/rcrq_out.sv @@
// Merges slot read data into the pending result and holds the output register
`default_nettype none
`include "assert_macros.svh"

module rcrq_out import rcrq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  s1_t        s1_d,
	input  slot_info_t ram_rdata,
	input  logic       rsp_stall,
	output logic       busy,
	output logic       rsp_valid,
	output rsp_beat_t  rsp
);

	logic      s1_valid_q;
	s1_t       s1_q;
	logic      rsp_valid_q;
	rsp_beat_t rsp_q;
	rsp_beat_t fin;
	logic      s1_adv;
	logic      hit_committed;

	assign s1_adv = !rsp_valid_q || !rsp_stall;
	assign busy   = s1_valid_q && !s1_adv;

	assign hit_committed = s1_q.entry_vld & ram_rdata.committed;

	always_comb begin
		fin = s1_q.res;
		if (s1_q.peek_hit) begin
			if (hit_committed) begin
				fin.status  = ST_OK;
				fin.out_len = ram_rdata.len;
			end else begin
				fin.status  = ST_PENDING;
				fin.out_len = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv)
				rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			s1_q <= s1_d;
		if (s1_adv && s1_valid_q)
			rsp_q <= fin;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RCRQ_ASSERT(a_hold_blocks_in, (s1_valid_q && rsp_valid_q && rsp_stall) |-> busy, "input open while both stages held")
	`RCRQ_NEVER(a_acc_when_busy, acc && busy, "beat accepted over a held stage")

endmodule

`default_nettype wire

@@ rtl/reserve_commit_ring_queue.sv @@
// Top level of the reserve/commit ring queue
// Slot bookkeeping for a ring of 64 slots. Each request beat (acquire, commit, peek,
// release or clear) gives exactly one response beat. A beat is accepted every cycle
// as long as the response side keeps up; after acceptance the result passes the
// stage-1 register, alongside the synchronous slot-record RAM read that peek needs,
// and then the output register. Head, tail, lost count and flush flag update at
// acceptance, and slot writes go to the RAM in the same cycle, so a peek right after
// a commit already sees it. Slot records are cleared by reset or clear through a
// per-slot valid bit, so no clearing pass is needed and the block is ready straight
// out of reset. req_stall rises only when a response is held by rsp_stall with a
// second one waiting behind it.
`default_nettype none

module reserve_commit_ring_queue import rcrq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	logic             acc;
	logic             busy;
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	slot_info_t       ram_wdata, ram_rdata;
	s1_t              s1_d;

	assign req_stall = busy;
	assign acc       = req_valid && !busy;

	rcrq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.req       (req),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.s1_d      (s1_d)
	);

	rcrq_ram #(
		.WIDTH (SLOT_INFO_W),
		.DEPTH (NUM_ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rcrq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.s1_d      (s1_d),
		.ram_rdata (ram_rdata),
		.rsp_stall (rsp_stall),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
